### sv/grc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// grc_pkg
// Shared types, widths and helpers for the grid ray DDA cast core.
// ----------------------------------------------------------------------------
package grc_pkg;

   localparam int MAP_DIM   = 64;
   localparam int FRAC_BITS = 16;
   localparam int DIR_FRAC  = 14;
   localparam int IDX_W     = $clog2(MAP_DIM);
   localparam int ADDR_W    = 2 * IDX_W;
   localparam int MAP_CELLS = MAP_DIM * MAP_DIM;
   localparam int CELL_W    = IDX_W + 2;
   localparam int POS_W     = 22;
   localparam int DIR_W     = 16;
   localparam int MAG_W     = 16;
   localparam int DELTA_W   = DIR_FRAC + FRAC_BITS + 1;
   localparam int SIDE_W    = DELTA_W + 8;
   localparam int NUM_W     = POS_W;
   localparam int DIV_W     = NUM_W + DIR_FRAC;
   localparam int DIST_W    = 24;
   localparam int DIST_RAW_W = FRAC_BITS + 1;
   localparam int QDEPTH    = 2;
   localparam int CSR_IDX_W = 2;

   localparam logic [DIST_W-1:0] DIST_MAX  = '1;
   localparam logic [DIV_W-1:0]  DELTA_NUM = DIV_W'(1) << (DIR_FRAC + FRAC_BITS);

   localparam logic OP_WRITE  = 1'b0;
   localparam logic OP_CAST   = 1'b1;
   localparam logic SIDE_X    = 1'b0;
   localparam logic SIDE_Y    = 1'b1;
   localparam logic STAT_OK   = 1'b0;
   localparam logic STAT_MISS = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_PLAYER_X = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PLAYER_Y = 2'd1;

   typedef struct packed {
      logic              op;
      logic [5:0]        cell_x;
      logic [5:0]        cell_y;
      logic              cell_wall;
      logic signed [15:0] ray_dx;
      logic signed [15:0] ray_dy;
   } req_type;

   typedef struct packed {
      logic [5:0]  hit_x;
      logic [5:0]  hit_y;
      logic        hit_side;
      logic [23:0] perp_dist;
      logic [23:0] full_dist;
      logic        status;
   } rsp_type;

   // classified request as it waits between front and back
   typedef struct packed {
      logic             op;
      logic [5:0]       cell_x;
      logic [5:0]       cell_y;
      logic             cell_wall;
      logic [MAG_W-1:0] mag_x;
      logic [MAG_W-1:0] mag_y;
      logic             neg_x;
      logic             neg_y;
   } job_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DIVX,
      ST_DIVY,
      ST_MUL,
      ST_WALK,
      ST_PERP,
      ST_OUT
   } back_state_type;

   function automatic logic [DIST_W-1:0] sat_dist(input logic [SIDE_W-1:0] v);
      sat_dist = (v > SIDE_W'(DIST_MAX)) ? DIST_MAX : v[DIST_W-1:0];
   endfunction

endpackage
`default_nettype wire

### sv/grc_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// grc_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module grc_div (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   input  wire logic [grc_pkg::DIV_W-1:0] dividend,
   input  wire logic [grc_pkg::MAG_W-1:0] divisor,
   output logic                           busy,
   output logic                           done,
   output logic [grc_pkg::DIV_W-1:0]      quotient
);
   localparam int CNT_W = $clog2(grc_pkg::DIV_W);

   logic                      busy_ff, done_ff;
   logic [CNT_W-1:0]          cnt_ff;
   logic [grc_pkg::DIV_W-1:0] quo_ff, quo_in;
   logic [grc_pkg::MAG_W-1:0] rem_ff, rem_in, dvs_ff;
   logic [grc_pkg::MAG_W:0]   rem_sh;
   logic                      ge;
   logic                      last;

   always_comb begin
      rem_sh = {rem_ff, quo_ff[grc_pkg::DIV_W-1]};
      ge     = rem_sh >= {1'b0, dvs_ff};
      rem_in = ge ? grc_pkg::MAG_W'(rem_sh - {1'b0, dvs_ff}) : rem_sh[grc_pkg::MAG_W-1:0];
      quo_in = {quo_ff[grc_pkg::DIV_W-2:0], ge};
      last   = cnt_ff == CNT_W'(grc_pkg::DIV_W - 1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (busy_ff) begin
         cnt_ff  <= cnt_ff + 1'b1;
         busy_ff <= !last;
         done_ff <= last;
      end else begin
         done_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         dvs_ff <= divisor;
      end else if (busy_ff) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
   end

   assign busy     = busy_ff;
   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule
`default_nettype wire

### sv/grc_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// grc_front
// Takes requests, classifies the ray direction and queues them for the back.
// ----------------------------------------------------------------------------
module grc_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire grc_pkg::req_type req_data,
   output logic                  job_valid,
   output grc_pkg::job_type      job,
   input  wire logic             job_pop
);
   localparam int PTR_W = $clog2(grc_pkg::QDEPTH);
   localparam int CNT_W = $clog2(grc_pkg::QDEPTH + 1);

   grc_pkg::job_type entry_ff [grc_pkg::QDEPTH];
   grc_pkg::job_type job_in;
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic             push;

   always_comb begin
      job_in.op        = req_data.op;
      job_in.cell_x    = req_data.cell_x;
      job_in.cell_y    = req_data.cell_y;
      job_in.cell_wall = req_data.cell_wall;
      job_in.neg_x     = req_data.ray_dx[grc_pkg::DIR_W-1];
      job_in.neg_y     = req_data.ray_dy[grc_pkg::DIR_W-1];
      // magnitude of -32768 still fits unsigned
      job_in.mag_x     = job_in.neg_x ? grc_pkg::MAG_W'(-req_data.ray_dx)
                                      : grc_pkg::MAG_W'(req_data.ray_dx);
      job_in.mag_y     = job_in.neg_y ? grc_pkg::MAG_W'(-req_data.ray_dy)
                                      : grc_pkg::MAG_W'(req_data.ray_dy);
   end

   assign req_ready = count_ff != CNT_W'(grc_pkg::QDEPTH);
   assign push      = req_valid && req_ready;
   assign job_valid = count_ff != '0;
   assign job       = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(grc_pkg::QDEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (job_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(grc_pkg::QDEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         count_ff <= count_ff + CNT_W'(push) - CNT_W'(job_pop);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= job_in;
      end
   end

`ifndef SYNTHESIS
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      job_pop |-> count_ff != '0)
      else $error("queue popped while empty");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(grc_pkg::QDEPTH))
      else $error("queue count out of range");

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      push |-> count_ff != CNT_W'(grc_pkg::QDEPTH))
      else $error("queue pushed while full");
`endif

endmodule
`default_nettype wire

### sv/grc_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// grc_back
// Wall map store, DDA walk sequencer and result register.
// ----------------------------------------------------------------------------
module grc_back (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      job_valid,
   input  wire grc_pkg::job_type          job,
   output logic                           job_pop,
   input  wire logic [grc_pkg::POS_W-1:0] player_x,
   input  wire logic [grc_pkg::POS_W-1:0] player_y,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output grc_pkg::rsp_type               rsp_data
);
   localparam int CW = grc_pkg::CELL_W;
   localparam int FB = grc_pkg::FRAC_BITS;
   localparam int PW = grc_pkg::DIST_RAW_W + grc_pkg::DELTA_W;

   grc_pkg::back_state_type state_ff, state_in;

   logic                         mem [grc_pkg::MAP_CELLS];
   logic                         rdata_ff;
   logic [grc_pkg::ADDR_W-1:0]   clr_addr_ff, wr_addr, rd_addr;
   logic                         mem_we, wr_bit, clr_last;

   logic [CW-1:0]                cx_ff, cy_ff, cx_in, cy_in;
   logic [grc_pkg::SIDE_W-1:0]   side_x_ff, side_y_ff;
   logic [grc_pkg::DELTA_W-1:0]  delta_x_ff, delta_y_ff;
   logic [grc_pkg::MAG_W-1:0]    mag_x_ff, mag_y_ff;
   logic                         neg_x_ff, neg_y_ff, inf_x, inf_y;
   logic                         first_ff, hside_ff;
   logic                         take_x, in_map;

   grc_pkg::rsp_type             res_ff, res_new, out_value, rsp_data_ff;
   logic                         rsp_valid_ff, out_free;

   // sequencer controls
   logic latch_job, cap_dx, cap_dy, mul_en, step_en, res_we, perp_we, load_out;
   logic div_start, div_busy, div_done;
   logic [grc_pkg::DIV_W-1:0]    div_dividend, div_q;
   logic [grc_pkg::MAG_W-1:0]    div_divisor;

   // walk datapath
   logic [grc_pkg::DIST_RAW_W-1:0] dist_x, dist_y;
   logic [PW-1:0]                  prod_x, prod_y;
   logic [grc_pkg::NUM_W:0]        edge_lo, edge_hi, pos_h;
   logic [grc_pkg::NUM_W-1:0]      num_h;
   logic                           neg_h, inf_h;
   logic [grc_pkg::SIDE_W-1:0]     side_h, delta_h;
   logic [grc_pkg::DIST_W-1:0]     full_h;

   grc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (div_q)
   );

   assign inf_x    = mag_x_ff == '0;
   assign inf_y    = mag_y_ff == '0;
   assign in_map   = (cx_ff[CW-1:CW-2] == 2'b00) && (cy_ff[CW-1:CW-2] == 2'b00);
   assign take_x   = !inf_x && (inf_y || side_x_ff < side_y_ff);
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign clr_last = clr_addr_ff == '1;

   // distance to first boundary per axis
   assign dist_x = neg_x_ff ? {1'b0, player_x[FB-1:0]}
                            : (grc_pkg::DIST_RAW_W'(1) << FB) - {1'b0, player_x[FB-1:0]};
   assign dist_y = neg_y_ff ? {1'b0, player_y[FB-1:0]}
                            : (grc_pkg::DIST_RAW_W'(1) << FB) - {1'b0, player_y[FB-1:0]};

   // full-width products for the initial side distances
   assign prod_x = PW'(dist_x) * PW'(delta_x_ff);
   assign prod_y = PW'(dist_y) * PW'(delta_y_ff);

   // boundary offset of the hit axis
   always_comb begin
      neg_h   = hside_ff ? neg_y_ff : neg_x_ff;
      inf_h   = hside_ff ? inf_y : inf_x;
      pos_h   = hside_ff ? (grc_pkg::NUM_W + 1)'(player_y) : (grc_pkg::NUM_W + 1)'(player_x);
      edge_lo = hside_ff ? (grc_pkg::NUM_W + 1)'({cy_ff, {FB{1'b0}}})
                         : (grc_pkg::NUM_W + 1)'({cx_ff, {FB{1'b0}}});
      edge_hi = edge_lo + ((grc_pkg::NUM_W + 1)'(1) << FB);
      if (neg_h) begin
         num_h = (pos_h >= edge_hi) ? grc_pkg::NUM_W'(pos_h - edge_hi) : '0;
      end else begin
         num_h = (edge_lo >= pos_h) ? grc_pkg::NUM_W'(edge_lo - pos_h) : '0;
      end
      side_h  = hside_ff ? side_y_ff : side_x_ff;
      delta_h = hside_ff ? grc_pkg::SIDE_W'(delta_y_ff) : grc_pkg::SIDE_W'(delta_x_ff);
      full_h  = inf_h ? grc_pkg::DIST_MAX : grc_pkg::sat_dist(side_h - delta_h);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         grc_pkg::ST_CLEAR: if (clr_last) state_in = grc_pkg::ST_IDLE;
         grc_pkg::ST_IDLE: begin
            if (job_valid && job.op == grc_pkg::OP_CAST) state_in = grc_pkg::ST_DIVX;
         end
         grc_pkg::ST_DIVX: if (div_done) state_in = grc_pkg::ST_DIVY;
         grc_pkg::ST_DIVY: if (div_done) state_in = grc_pkg::ST_MUL;
         grc_pkg::ST_MUL:  state_in = grc_pkg::ST_WALK;
         grc_pkg::ST_WALK: begin
            priority if (first_ff && rdata_ff) state_in = grc_pkg::ST_OUT;
            else if (!first_ff && !in_map)     state_in = grc_pkg::ST_OUT;
            else if (!first_ff && rdata_ff)    state_in = grc_pkg::ST_PERP;
            else                               state_in = grc_pkg::ST_WALK;
         end
         grc_pkg::ST_PERP: if (div_done) state_in = grc_pkg::ST_OUT;
         grc_pkg::ST_OUT:  if (out_free) state_in = grc_pkg::ST_IDLE;
         default:          state_in = grc_pkg::ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      job_pop      = 1'b0;
      latch_job    = 1'b0;
      mem_we       = 1'b0;
      cap_dx       = 1'b0;
      cap_dy       = 1'b0;
      mul_en       = 1'b0;
      step_en      = 1'b0;
      res_we       = 1'b0;
      perp_we      = 1'b0;
      load_out     = 1'b0;
      div_start    = 1'b0;
      div_dividend = grc_pkg::DELTA_NUM;
      div_divisor  = mag_y_ff;
      res_new      = res_ff;
      out_value    = res_ff;
      unique case (state_ff)
         grc_pkg::ST_CLEAR: mem_we = 1'b1;
         grc_pkg::ST_IDLE: begin
            if (job_valid && job.op == grc_pkg::OP_WRITE && out_free) begin
               job_pop   = 1'b1;
               mem_we    = 1'b1;
               load_out  = 1'b1;
               out_value = '0;
            end else if (job_valid && job.op == grc_pkg::OP_CAST) begin
               job_pop     = 1'b1;
               latch_job   = 1'b1;
               div_start   = 1'b1;
               div_divisor = job.mag_x;
            end
         end
         grc_pkg::ST_DIVX: begin
            if (div_done) begin
               cap_dx    = 1'b1;
               div_start = 1'b1;
            end
         end
         grc_pkg::ST_DIVY: cap_dy = div_done;
         grc_pkg::ST_MUL:  mul_en = 1'b1;
         grc_pkg::ST_WALK: begin
            priority if (first_ff && rdata_ff) begin
               // standing inside a wall
               res_we            = 1'b1;
               res_new           = '0;
               res_new.hit_x     = cx_ff[grc_pkg::IDX_W-1:0];
               res_new.hit_y     = cy_ff[grc_pkg::IDX_W-1:0];
               res_new.hit_side  = grc_pkg::SIDE_X;
               res_new.status    = grc_pkg::STAT_OK;
            end else if (!first_ff && !in_map) begin
               res_we            = 1'b1;
               res_new           = '0;
               res_new.perp_dist = grc_pkg::DIST_MAX;
               res_new.full_dist = grc_pkg::DIST_MAX;
               res_new.status    = grc_pkg::STAT_MISS;
            end else if (!first_ff && rdata_ff) begin
               res_we            = 1'b1;
               res_new.hit_x     = cx_ff[grc_pkg::IDX_W-1:0];
               res_new.hit_y     = cy_ff[grc_pkg::IDX_W-1:0];
               res_new.hit_side  = hside_ff;
               res_new.perp_dist = '0;
               res_new.full_dist = full_h;
               res_new.status    = grc_pkg::STAT_OK;
               div_start         = 1'b1;
               div_dividend      = {num_h, {grc_pkg::DIR_FRAC{1'b0}}};
               div_divisor       = hside_ff ? mag_y_ff : mag_x_ff;
            end else begin
               step_en = 1'b1;
            end
         end
         grc_pkg::ST_PERP: perp_we = div_done;
         grc_pkg::ST_OUT:  load_out = out_free;
         default: ;
      endcase
   end

   // cell walk; the store is read at the next cell so data lines up with it
   always_comb begin
      cx_in = cx_ff;
      cy_in = cy_ff;
      if (latch_job) begin
         cx_in = CW'(player_x[grc_pkg::POS_W-1:FB]);
         cy_in = CW'(player_y[grc_pkg::POS_W-1:FB]);
      end else if (step_en && take_x) begin
         cx_in = cx_ff + (neg_x_ff ? {CW{1'b1}} : CW'(1));
      end else if (step_en) begin
         cy_in = cy_ff + (neg_y_ff ? {CW{1'b1}} : CW'(1));
      end
      rd_addr = {cy_in[grc_pkg::IDX_W-1:0], cx_in[grc_pkg::IDX_W-1:0]};
      wr_addr = (state_ff == grc_pkg::ST_CLEAR) ? clr_addr_ff : {job.cell_y, job.cell_x};
      wr_bit  = (state_ff == grc_pkg::ST_CLEAR) ? 1'b0 : job.cell_wall;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_addr] <= wr_bit;
      end
      rdata_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= grc_pkg::ST_CLEAR;
         clr_addr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         if (state_ff == grc_pkg::ST_CLEAR) begin
            clr_addr_ff <= clr_addr_ff + 1'b1;
         end
         rsp_valid_ff <= load_out || (rsp_valid_ff && !rsp_ready);
      end
   end

   always_ff @(posedge clock) begin
      cx_ff <= cx_in;
      cy_ff <= cy_in;
      if (latch_job) begin
         mag_x_ff <= job.mag_x;
         mag_y_ff <= job.mag_y;
         neg_x_ff <= job.neg_x;
         neg_y_ff <= job.neg_y;
      end
      if (cap_dx) delta_x_ff <= div_q[grc_pkg::DELTA_W-1:0];
      if (cap_dy) delta_y_ff <= div_q[grc_pkg::DELTA_W-1:0];
      if (mul_en) begin
         side_x_ff <= grc_pkg::SIDE_W'(prod_x >> FB);
         side_y_ff <= grc_pkg::SIDE_W'(prod_y >> FB);
         first_ff  <= 1'b1;
         hside_ff  <= grc_pkg::SIDE_X;
      end else if (step_en) begin
         first_ff <= 1'b0;
         if (take_x) begin
            side_x_ff <= side_x_ff + grc_pkg::SIDE_W'(delta_x_ff);
            hside_ff  <= grc_pkg::SIDE_X;
         end else begin
            if (!inf_y) side_y_ff <= side_y_ff + grc_pkg::SIDE_W'(delta_y_ff);
            hside_ff <= grc_pkg::SIDE_Y;
         end
      end
      if (res_we) begin
         res_ff <= res_new;
      end else if (perp_we) begin
         res_ff.perp_dist <= inf_h ? grc_pkg::DIST_MAX
                                   : grc_pkg::sat_dist(grc_pkg::SIDE_W'(div_q));
      end
      if (load_out) begin
         rsp_data_ff <= out_value;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   a_div_free: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_busy)
      else $error("divider started while busy");

   a_div_wait: assert property (@(posedge clock) disable iff (reset)
      (state_ff == grc_pkg::ST_PERP || state_ff == grc_pkg::ST_DIVX
       || state_ff == grc_pkg::ST_DIVY) |-> (div_busy || div_done))
      else $error("waiting on an idle divider");

   a_miss_max: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.status == grc_pkg::STAT_MISS)
      |-> (rsp_data_ff.perp_dist == grc_pkg::DIST_MAX
           && rsp_data_ff.full_dist == grc_pkg::DIST_MAX))
      else $error("missed ray without saturated distances");
`endif

endmodule
`default_nettype wire

### sv/grid_ray_dda_cast_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// grid_ray_dda_cast_core
// Grid ray caster: wall map writes and DDA ray casts from the player position.
//
//   channel  direction  handshake              payload
//   req      in         req_valid/req_ready    req_data  (grc_pkg::req_type)
//   rsp      out        rsp_valid/rsp_ready    rsp_data  (grc_pkg::rsp_type)
//   csr      in         csr_valid/csr_ready    csr_index, csr_wdata
//
// A cast that hits takes three runs of the shared bit-serial divider and
// steps at most 126 cells; the walk reads one map cell per cycle. A miss
// or a start inside a wall skips the last divider run. After reset the
// map is cleared, during which no request leaves the two-entry queue.
// Either side may stall; a finished response waits in its register while
// requests queue.
// ----------------------------------------------------------------------------
module grid_ray_dda_cast_core (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire grc_pkg::req_type              req_data,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output grc_pkg::rsp_type                   rsp_data,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [grc_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [grc_pkg::POS_W-1:0]     csr_wdata
);
   logic [grc_pkg::POS_W-1:0] player_x_ff, player_y_ff;
   logic                      job_valid, job_pop;
   grc_pkg::job_type          job;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         player_x_ff <= '0;
         player_y_ff <= '0;
      end else if (csr_valid) begin
         if (csr_index == grc_pkg::CSR_PLAYER_X) player_x_ff <= csr_wdata;
         if (csr_index == grc_pkg::CSR_PLAYER_Y) player_y_ff <= csr_wdata;
      end
   end

   grc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .job_valid (job_valid),
      .job       (job),
      .job_pop   (job_pop)
   );

   grc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (job_valid),
      .job       (job),
      .job_pop   (job_pop),
      .player_x  (player_x_ff),
      .player_y  (player_y_ff),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire
